// ===== hw/rtl/rps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rps_pkg
// Types and constants shared by the rotor prerotation sequencer modules.
// ----------------------------------------------------------------------------
package rps_pkg;

  // Rotor phase codes
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_RAMP   = 3'd2;
  localparam logic [2:0] PH_TARGET = 3'd3;
  localparam logic [2:0] PH_OFF    = 3'd4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_WAIT_RPM     = 3'd0,
    CFG_TARGET_RPM   = 3'd1,
    CFG_RAMP_TIME_MS = 3'd2,
    CFG_PULSE_MIN_US = 3'd3,
    CFG_PULSE_MAX_US = 3'd4,
    CFG_PULSE_IDLE   = 3'd5,
    CFG_END_AIRSPEED = 3'd6
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;
  localparam int PW_W       = 11;

  // Drive conversion: q = round(|pw - 1500| * 4096 / 125), saturated
  localparam logic [11:0]        PW_CENTER   = 12'd1500;
  localparam logic [10:0]        PW_SAT_MAG  = 11'd500;
  localparam logic [20:0]        ROUND_BIAS  = 21'd62;
  localparam logic signed [15:0] DRIVE_OFF   = -16'sd16384;
  localparam logic signed [15:0] DRIVE_FULL  = 16'sd16384;

  // Divide by 125 as multiply by ceil(2^26 / 125) and shift right by 26;
  // exact for every numerator below 2^21
  localparam logic [19:0] Q14_RECIP = 20'd536871;
  localparam int          Q14_SHIFT = 26;

  // Divider geometry
  localparam int DIV_REM_W  = 17;
  localparam int DIV_BITS_W = 14;
  localparam int DIV_CNT_W  = 4;
  localparam logic [DIV_CNT_W-1:0] STEPS_RAMP = 4'd11;

  typedef struct packed {
    logic [15:0] wait_rpm;
    logic [15:0] target_rpm;
    logic [15:0] ramp_time_ms;
    logic [10:0] pulse_min_us;
    logic [10:0] pulse_max_us;
    logic [10:0] pulse_idle_us;
    logic [15:0] end_airspeed_cms;
  } cfg_t;

  // Request to the divider: remainder preload, left-aligned dividend
  // bits still to shift in, divisor and number of quotient bits
  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_BITS_W-1:0] bits;
    logic [15:0]           divisor;
    logic [DIV_CNT_W-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_BITS_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rps_if
// Valid/ready channels for control ticks and drive results.
// ----------------------------------------------------------------------------
interface rps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        armed;
  logic [15:0] rotor_rpm;
  logic [15:0] airspeed_cms;

  modport source (output valid, now_ms, armed, rotor_rpm, airspeed_cms, input ready);
  modport sink   (input valid, now_ms, armed, rotor_rpm, airspeed_cms, output ready);
endinterface

interface rps_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_q14;
  logic [2:0]         phase_out;

  modport source (output valid, drive_q14, phase_out, input ready);
  modport sink   (input valid, drive_q14, phase_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rps_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rps_cfg_regs
// Configuration register bank, write-only, reset to operating defaults.
// ----------------------------------------------------------------------------
module rps_cfg_regs
  import rps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_rpm         <= 16'd100;
      cfg_r.target_rpm       <= 16'd200;
      cfg_r.ramp_time_ms     <= 16'd5000;
      cfg_r.pulse_min_us     <= 11'd1000;
      cfg_r.pulse_max_us     <= 11'd2000;
      cfg_r.pulse_idle_us    <= 11'd1000;
      cfg_r.end_airspeed_cms <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_WAIT_RPM:     cfg_r.wait_rpm         <= cfg_wdata;
        CFG_TARGET_RPM:   cfg_r.target_rpm       <= cfg_wdata;
        CFG_RAMP_TIME_MS: cfg_r.ramp_time_ms     <= cfg_wdata;
        CFG_PULSE_MIN_US: cfg_r.pulse_min_us     <= cfg_wdata[PW_W-1:0];
        CFG_PULSE_MAX_US: cfg_r.pulse_max_us     <= cfg_wdata[PW_W-1:0];
        CFG_PULSE_IDLE:   cfg_r.pulse_idle_us    <= cfg_wdata[PW_W-1:0];
        CFG_END_AIRSPEED: cfg_r.end_airspeed_cms <= cfg_wdata;
        default: ; // drop writes to unmapped index
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rps_div
// Restoring divider, one quotient bit per cycle. The caller preloads
// the upper dividend bits as partial remainder (must be below the divisor).
// ----------------------------------------------------------------------------
module rps_div
  import rps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_REM_W-1:0]  rem_r;
  logic [DIV_BITS_W-1:0] sh_r;
  logic [DIV_BITS_W-1:0] q_r;
  logic [15:0]           dvs_r;

  logic [DIV_REM_W+1:0]  diff;
  logic                  borrow;
  logic [DIV_REM_W-1:0]  rem_nxt;

  always_comb begin
    diff    = {1'b0, rem_r, sh_r[DIV_BITS_W-1]} - {3'b000, dvs_r};
    borrow  = diff[DIV_REM_W+1];
    rem_nxt = borrow ? {rem_r[DIV_REM_W-2:0], sh_r[DIV_BITS_W-1]} : diff[DIV_REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      sh_r  <= req.bits;
      dvs_r <= req.divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[DIV_BITS_W-2:0], 1'b0};
      q_r   <= {q_r[DIV_BITS_W-2:0], ~borrow};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rotor_prerotation_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tick to result: start, wait and off end in idle; target phase or past the
// ramp time adds conversion and, unsaturated, scaling; ramp phase first adds
// both multiplies and the serial divider (one quotient bit per cycle). One
// tick in flight; the next is taken once the result is registered for output.
// Synchronous active-low reset: phase to start, ramp start time and
// configuration registers to their defaults, no result pending.
// ----------------------------------------------------------------------------
// rotor_prerotation_sequencer_top
// Phase sequencer and drive computation around a shared multiplier/divider.
// ----------------------------------------------------------------------------
module rotor_prerotation_sequencer_top
  import rps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rps_in_if.sink                     in_ch,
  rps_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL0  = 7'b0000010,
    S_MUL1  = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_DIV1  = 7'b0010000,
    S_CONV  = 7'b0100000,
    S_SCALE = 7'b1000000
  } state_t;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t             state_r, state_nxt;
  logic [2:0]         phase_r;
  logic [2:0]         phase_nxt;
  logic [31:0]        ramp_start_r;
  logic [15:0]        e_r;
  logic [27:0]        acc_r;
  logic [PW_W-1:0]    pw_r;
  logic               neg_r;
  logic [20:0]        q14_num_r;
  logic               res_pend_r;
  logic signed [15:0] res_drive_r;
  logic               out_valid_r;
  logic signed [15:0] out_drive_r;
  logic [2:0]         out_phase_r;

  logic               in_fire;
  logic               out_free;
  logic [2:0]         ph0;
  logic [31:0]        elapsed;
  logic [10:0]        mul_a;
  logic [15:0]        mul_b;
  logic [26:0]        prod;
  logic signed [11:0] pw_diff;
  logic [10:0]        pw_mag;
  logic               mag_sat;
  logic [20:0]        q14_num;
  logic [40:0]        q14_prod;
  logic [13:0]        q14_mag;

  rps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE) && !res_pend_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Disarm drops back to start before the phase step
  assign ph0     = (phase_r != PH_START && !in_ch.armed) ? PH_START : phase_r;
  assign elapsed = in_ch.now_ms - ramp_start_r;

  always_comb begin
    phase_nxt = ph0;
    case (ph0)
      PH_START:  if (in_ch.armed) phase_nxt = PH_WAIT;
      PH_WAIT:   if (in_ch.rotor_rpm >= cfg.wait_rpm) phase_nxt = PH_RAMP;
      PH_RAMP:   if (in_ch.rotor_rpm > cfg.target_rpm) phase_nxt = PH_TARGET;
      PH_TARGET: if (in_ch.airspeed_cms > cfg.end_airspeed_cms) phase_nxt = PH_OFF;
      default: ;
    endcase
  end

  // Shared multiplier: min*(T-e) first, then max*e
  always_comb begin
    if (state_r == S_MUL0) begin
      mul_a = cfg.pulse_min_us;
      mul_b = cfg.ramp_time_ms - e_r;
    end else begin
      mul_a = cfg.pulse_max_us;
      mul_b = e_r;
    end
    prod = 27'(mul_a) * 27'(mul_b);
  end

  always_comb begin
    pw_diff  = $signed({1'b0, pw_r}) - $signed(PW_CENTER);
    pw_mag   = pw_diff[11] ? 11'(-pw_diff) : pw_diff[10:0];
    mag_sat  = pw_mag >= PW_SAT_MAG;
    q14_num  = {pw_mag[8:0], 12'b0} + ROUND_BIAS;
    q14_prod = 41'(q14_num_r) * 41'(Q14_RECIP);
    q14_mag  = q14_prod[Q14_SHIFT+13:Q14_SHIFT];
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_LOAD) begin
      div_req.start    = 1'b1;
      div_req.rem_init = acc_r[27:PW_W];
      div_req.bits     = {acc_r[PW_W-1:0], 3'b000};
      div_req.divisor  = cfg.ramp_time_ms;
      div_req.steps    = STEPS_RAMP;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_IDLE;
          if (ph0 == PH_RAMP) begin
            state_nxt = (elapsed < {16'b0, cfg.ramp_time_ms}) ? S_MUL0 : S_CONV;
          end else if (ph0 == PH_TARGET) begin
            state_nxt = S_CONV;
          end
        end
      end
      S_MUL0:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV1;
      S_DIV1:  if (div_rsp.done) state_nxt = S_CONV;
      S_CONV:  state_nxt = mag_sat ? S_IDLE : S_SCALE;
      S_SCALE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_START;
      ramp_start_r <= '0;
      res_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        if (ph0 == PH_WAIT && phase_nxt == PH_RAMP) begin
          ramp_start_r <= in_ch.now_ms;
        end
      end

      // Raise pending when the drive value is final
      if ((state_r == S_IDLE && in_fire && ph0 != PH_RAMP && ph0 != PH_TARGET)
          || (state_r == S_CONV && mag_sat)
          || (state_r == S_SCALE)) begin
        res_pend_r <= 1'b1;
      end else if (res_pend_r && out_free) begin
        res_pend_r <= 1'b0;
      end

      if (res_pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_r         <= elapsed[15:0];
      pw_r        <= cfg.pulse_idle_us;
      res_drive_r <= DRIVE_OFF;
    end
    if (state_r == S_MUL0) begin
      acc_r <= 28'(prod);
    end
    if (state_r == S_MUL1) begin
      acc_r <= acc_r + 28'(prod);
    end
    if (state_r == S_DIV1 && div_rsp.done) begin
      pw_r <= div_rsp.quotient[PW_W-1:0];
    end
    if (state_r == S_CONV) begin
      neg_r     <= pw_diff[11];
      q14_num_r <= q14_num;
      if (mag_sat) begin
        res_drive_r <= pw_diff[11] ? DRIVE_OFF : DRIVE_FULL;
      end
    end
    if (state_r == S_SCALE) begin
      res_drive_r <= neg_r ? -$signed({2'b00, q14_mag})
                           : $signed({2'b00, q14_mag});
    end
    if (res_pend_r && out_free) begin
      out_drive_r <= res_drive_r;
      out_phase_r <= phase_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive_q14 = out_drive_r;
  assign out_ch.phase_out = out_phase_r;

endmodule
`default_nettype wire
